// ----- rtl/sc3_pkg.sv -----
// Shared types and constants for the 3x3 luma sharpening filter.
// No dependencies; imported by sharpen_conv3x3_clamp.
package sc3_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIX_W      = 8;
    localparam int PIXEL_W    = 3 * PIX_W;
    localparam int KROW_W     = 24;
    localparam int DIM_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int TAPS       = 3;
    localparam int BANKS      = 4;
    localparam int BANK_W     = 2;
    localparam int PROD_W     = 17;
    localparam int SUM_W      = 21;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int OCC_W      = FIFO_AW + 2;

    localparam logic [KROW_W-1:0] KROW_TOP_RST = 24'h00FF00;
    localparam logic [KROW_W-1:0] KROW_MID_RST = 24'hFF05FF;
    localparam logic [KROW_W-1:0] KROW_BOT_RST = 24'h00FF00;
    localparam logic [DIM_W-1:0]  WIDTH_RST    = 11'd640;
    localparam logic [DIM_W-1:0]  HEIGHT_RST   = 11'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_TOP = 3'd0,
        CFG_KERNEL_MID = 3'd1,
        CFG_KERNEL_BOT = 3'd2,
        CFG_WIDTH      = 3'd3,
        CFG_HEIGHT     = 3'd4
    } t_cfg_index;

    // read-stage control: row banks, column-0 reload, same-cycle write forwarding
    typedef struct packed {
        logic                         first;
        logic                         last;
        logic [TAPS-1:0][BANK_W-1:0]  row_bank;
        logic                         fwd_a;
        logic                         fwd_b;
        logic [BANK_W-1:0]            wbank;
    } t_s1_ctl;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] cr;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] luma;
    } t_result;

endpackage

// ----- rtl/sharpen_conv3x3_clamp.sv -----
// 3x3 luma convolution with replicate borders, Cb/Cr of centre passed through.
// Four row banks of MAX_WIDTH pixels, window, multiply, sum/clamp, output FIFO.
// Depends on sc3_pkg.
//
//  channel   | dir | handshake                          | payload
//  ----------+-----+------------------------------------+----------------------------------
//  s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready  | tdata Y,Cb,Cr; tuser kind (1=drain)
//  m_axis    | out | o_m_axis_tvalid / i_m_axis_tready  | tdata Y,Cb,Cr; tlast frame end
//  cfg       | in  | i_cfg_valid / o_cfg_ready          | i_cfg_index, i_cfg_data
//
// One request per clock sustained while the output FIFO has room. A result for the request that
// completes its window passes bank read, window shift, multiply, sum and clamp into the FIFO.
// Reset clears positions, pipeline and FIFO; the row banks need no clearing pass.
// The input stalls only when the 8-entry output FIFO plus in-flight results are full.
module sharpen_conv3x3_clamp
    import sc3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [PIXEL_W-1:0]    i_s_axis_tdata,   // [7:0] Y, [15:8] Cb, [23:16] Cr
    input  logic                  i_s_axis_tuser,   // [0] kind: 0 pixel, 1 drain
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [PIXEL_W-1:0]    o_m_axis_tdata,   // [7:0] Y, [15:8] Cb, [23:16] Cr
    output logic                  o_m_axis_tlast
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int PW = RW + DIM_W;
    localparam int XW = PW + 1;

    // configuration
    logic [KROW_W-1:0] r_kernel [TAPS];
    logic [DIM_W-1:0]  r_frame_width;
    logic [DIM_W-1:0]  r_frame_height;

    // positions
    logic [CW-1:0] r_in_col,  n_in_col;
    logic [RW-1:0] r_in_row,  n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;

    logic [DIM_W-1:0] w_width, w_height;
    logic [XW-1:0]    w_wx, w_hx;
    logic             w_accept, w_in_frame, w_step, w_wr_en, w_due, w_emit, w_last;
    logic [RW-1:0]    w_dr;
    logic [PW-1:0]    w_prod;
    logic [XW-1:0]    w_in_c1, w_out_c1, w_col_a1;
    logic [CW-1:0]    w_col_a;
    logic [XW-1:0]    w_row_c, w_row_m, w_row_p, w_row_mraw, w_row_praw;

    // row banks and pipeline
    logic [PIXEL_W-1:0] r_rd_a [BANKS];
    logic [PIXEL_W-1:0] r_rd_b [BANKS];
    logic               r_s1_valid;
    t_s1_ctl            r_s1;
    logic [PIXEL_W-1:0] r_s1_wdata;
    logic [PIXEL_W-1:0] r_win [TAPS][TAPS];
    logic [PIXEL_W-1:0] n_win [TAPS][TAPS];
    logic               r_s2_valid, r_s2_last;
    logic signed [PROD_W-1:0] r_prod [TAPS][TAPS];
    logic signed [PROD_W-1:0] n_prod [TAPS][TAPS];
    logic [2*PIX_W-1:0] r_s3_chroma;
    logic               r_s3_valid, r_s3_last;
    logic signed [SUM_W-1:0] w_sum;
    logic               w_neg, w_over;
    t_result            w_push_item;

    // output FIFO
    t_result            r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               w_pop;
    logic [OCC_W-1:0]   w_busy;
    t_result            w_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel[0]    <= KROW_TOP_RST;
            r_kernel[1]    <= KROW_MID_RST;
            r_kernel[2]    <= KROW_BOT_RST;
            r_frame_width  <= WIDTH_RST;
            r_frame_height <= HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KERNEL_TOP: r_kernel[0]    <= i_cfg_data;
                CFG_KERNEL_MID: r_kernel[1]    <= i_cfg_data;
                CFG_KERNEL_BOT: r_kernel[2]    <= i_cfg_data;
                CFG_WIDTH:      r_frame_width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT:     r_frame_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_frame_width == '0) begin
            w_width = DIM_W'(1);
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            w_width = DIM_W'(MAX_WIDTH);
        end else begin
            w_width = r_frame_width;
        end
        if (r_frame_height == '0) begin
            w_height = DIM_W'(1);
        end else if (int'(r_frame_height) > MAX_HEIGHT) begin
            w_height = DIM_W'(MAX_HEIGHT);
        end else begin
            w_height = r_frame_height;
        end
    end

    assign w_wx = XW'(w_width);
    assign w_hx = XW'(w_height);

    // request bookkeeping
    assign w_accept   = i_s_axis_tvalid & o_s_axis_tready;
    assign w_in_frame = XW'(r_in_row) < w_hx;
    assign w_step     = w_accept & ~(w_in_frame & i_s_axis_tuser);
    assign w_wr_en    = w_accept & w_in_frame & ~i_s_axis_tuser
                      & (XW'(r_in_col) < XW'(MAX_WIDTH));

    // result due once input index reaches output index + width + 1
    assign w_dr   = r_in_row - r_out_row;
    assign w_prod = PW'(w_dr) * PW'(w_width);
    assign w_due  = (XW'(w_prod) + XW'(r_in_col)) >= (XW'(r_out_col) + w_wx + XW'(1));
    assign w_emit = w_step & w_due;
    assign w_last = ((XW'(r_out_row) + XW'(1)) >= w_hx)
                  && ((XW'(r_out_col) + XW'(1)) >= w_wx);

    assign w_in_c1  = XW'(r_in_col) + XW'(1);
    assign w_out_c1 = XW'(r_out_col) + XW'(1);

    always_comb begin
        if (w_in_c1 >= w_wx) begin
            n_in_col = '0;
            n_in_row = r_in_row + RW'(1);
        end else begin
            n_in_col = CW'(w_in_c1);
            n_in_row = r_in_row;
        end
        if (w_out_c1 >= w_wx) begin
            n_out_col = '0;
            n_out_row = r_out_row + RW'(1);
        end else begin
            n_out_col = CW'(w_out_c1);
            n_out_row = r_out_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (w_emit && w_last) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            if (w_step) begin
                r_in_col <= n_in_col;
                r_in_row <= n_in_row;
            end
            if (w_emit) begin
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
            end
        end
    end

    // read addresses: right column and the three clamped rows
    assign w_col_a1   = (w_out_c1 >= w_wx) ? (w_wx - XW'(1)) : w_out_c1;
    assign w_col_a    = CW'(w_col_a1);
    assign w_row_c    = (XW'(r_out_row) >= w_hx) ? (w_hx - XW'(1)) : XW'(r_out_row);
    assign w_row_mraw = (r_out_row == '0) ? '0 : (XW'(r_out_row) - XW'(1));
    assign w_row_m    = (w_row_mraw >= w_hx) ? (w_hx - XW'(1)) : w_row_mraw;
    assign w_row_praw = XW'(r_out_row) + XW'(1);
    assign w_row_p    = (w_row_praw >= w_hx) ? (w_hx - XW'(1)) : w_row_praw;

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        logic [PIXEL_W-1:0] r_mem [MAX_WIDTH];
        always_ff @(posedge i_clk) begin
            if (w_wr_en && (r_in_row[BANK_W-1:0] == BANK_W'(b))) begin
                r_mem[r_in_col] <= i_s_axis_tdata;
            end
            r_rd_a[b] <= r_mem[w_col_a];
            r_rd_b[b] <= r_mem[CW'(0)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_emit;
        end
        r_s1.first       <= (r_out_col == '0);
        r_s1.last        <= w_last;
        r_s1.row_bank[0] <= w_row_m[BANK_W-1:0];
        r_s1.row_bank[1] <= w_row_c[BANK_W-1:0];
        r_s1.row_bank[2] <= w_row_p[BANK_W-1:0];
        r_s1.fwd_a       <= w_wr_en && (r_in_col == w_col_a);
        r_s1.fwd_b       <= w_wr_en && (r_in_col == '0);
        r_s1.wbank       <= r_in_row[BANK_W-1:0];
        r_s1_wdata       <= i_s_axis_tdata;
    end

    // window: reload at column 0, else shift left and take the new right column
    always_comb begin
        logic [BANK_W-1:0]  v_bank;
        logic [PIXEL_W-1:0] v_a;
        logic [PIXEL_W-1:0] v_b;
        for (int j = 0; j < TAPS; j++) begin
            v_bank = r_s1.row_bank[j];
            v_a = (r_s1.fwd_a && (r_s1.wbank == v_bank)) ? r_s1_wdata : r_rd_a[v_bank];
            v_b = (r_s1.fwd_b && (r_s1.wbank == v_bank)) ? r_s1_wdata : r_rd_b[v_bank];
            if (r_s1.first) begin
                n_win[j][0] = v_b;
                n_win[j][1] = v_b;
            end else begin
                n_win[j][0] = r_win[j][1];
                n_win[j][1] = r_win[j][2];
            end
            n_win[j][2] = v_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_last <= r_s1.last;
        if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    always_comb begin
        for (int j = 0; j < TAPS; j++) begin
            for (int i = 0; i < TAPS; i++) begin
                n_prod[j][i] = $signed({1'b0, r_win[j][i][PIX_W-1:0]})
                             * $signed(r_kernel[j][PIX_W*i +: PIX_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_last   <= r_s2_last;
        r_s3_chroma <= r_win[1][1][PIXEL_W-1:PIX_W];
        r_prod      <= n_prod;
    end

    always_comb begin
        w_sum = '0;
        for (int j = 0; j < TAPS; j++) begin
            for (int i = 0; i < TAPS; i++) begin
                w_sum = w_sum + SUM_W'(r_prod[j][i]);
            end
        end
    end

    assign w_neg  = w_sum[SUM_W-1];
    assign w_over = ~w_neg & (|w_sum[SUM_W-2:PIX_W]);

    always_comb begin
        w_push_item.last = r_s3_last;
        w_push_item.cb   = r_s3_chroma[PIX_W-1:0];
        w_push_item.cr   = r_s3_chroma[2*PIX_W-1:PIX_W];
        if (w_neg) begin
            w_push_item.luma = '0;
        end else if (w_over) begin
            w_push_item.luma = '1;
        end else begin
            w_push_item.luma = w_sum[PIX_W-1:0];
        end
    end

    // output FIFO; input held off while FIFO plus in-flight results fill it
    assign w_head          = r_fifo[r_rd_ptr];
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = {w_head.cr, w_head.cb, w_head.luma};
    assign o_m_axis_tlast  = w_head.last;
    assign w_pop           = o_m_axis_tvalid & i_m_axis_tready;
    assign w_busy          = OCC_W'(r_count) + OCC_W'(r_s1_valid)
                           + OCC_W'(r_s2_valid) + OCC_W'(r_s3_valid);
    assign o_s_axis_tready = (w_busy < OCC_W'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (r_s3_valid) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + (FIFO_AW+1)'(r_s3_valid) - (FIFO_AW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_valid) begin
            r_fifo[r_wr_ptr] <= w_push_item;
        end
    end

    a_fifo_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && !w_pop) |-> (r_count < (FIFO_AW+1)'(FIFO_DEPTH)))
        else $error("result pushed into full output FIFO");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> (r_in_col == '0 && r_in_row == '0
                                && r_out_col == '0 && r_out_row == '0))
        else $error("positions not cleared after frame end");

    a_last_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && r_s3_last) |-> !(r_s2_valid && r_s2_last))
        else $error("two consecutive frame-end results");

    a_drain_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_in_frame && i_s_axis_tuser) |=> !r_s1_valid)
        else $error("early drain request produced a result");

endmodule

// ----- sim/tb_top.sv -----
// Testbench for sharpen_conv3x3_clamp: 3x3 luma sharpening with clamped borders on a pixel stream.
// A scoreboard class predicts each output pixel; directed and random frames run under back-pressure.
// Depends on sc3_pkg and the sharpen_conv3x3_clamp RTL.

class luma_sharpen_scoreboard;
    bit [sc3_pkg::KROW_W-1:0]  kernel_rows [sc3_pkg::TAPS];
    bit [sc3_pkg::DIM_W-1:0]   width_reg;
    bit [sc3_pkg::DIM_W-1:0]   height_reg;
    bit [sc3_pkg::PIXEL_W-1:0] line_pixels [sc3_pkg::BANKS * sc3_pkg::DEF_MAX_WIDTH];
    int                        in_col;
    int                        in_row;
    int                        out_col;
    int                        out_row;
    sc3_pkg::t_result          expected_pixels [$];
    int                        mismatches;

    function new();
        kernel_rows[0] = sc3_pkg::KROW_TOP_RST;
        kernel_rows[1] = sc3_pkg::KROW_MID_RST;
        kernel_rows[2] = sc3_pkg::KROW_BOT_RST;
        width_reg      = sc3_pkg::WIDTH_RST;
        height_reg     = sc3_pkg::HEIGHT_RST;
        in_col         = 0;
        in_row         = 0;
        out_col        = 0;
        out_row        = 0;
        mismatches     = 0;
    endfunction

    static function int clamp_dim(bit [sc3_pkg::DIM_W-1:0] v, int limit);
        if (v == 0) return 1;
        if (int'(v) > limit) return limit;
        return int'(v);
    endfunction

    function void set_register(bit [sc3_pkg::CFG_IDX_W-1:0] idx,
                               bit [sc3_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            sc3_pkg::CFG_KERNEL_TOP: kernel_rows[0] = value;
            sc3_pkg::CFG_KERNEL_MID: kernel_rows[1] = value;
            sc3_pkg::CFG_KERNEL_BOT: kernel_rows[2] = value;
            sc3_pkg::CFG_WIDTH:      width_reg = value[sc3_pkg::DIM_W-1:0];
            sc3_pkg::CFG_HEIGHT:     height_reg = value[sc3_pkg::DIM_W-1:0];
            default: ;
        endcase
    endfunction

    // replicate border: positions are clamped into the frame
    function bit [sc3_pkg::PIXEL_W-1:0] window_tap(int r, int c, int w, int h);
        if (r < 0) r = 0;
        if (r > h - 1) r = h - 1;
        if (c < 0) c = 0;
        if (c > w - 1) c = w - 1;
        return line_pixels[(r % sc3_pkg::BANKS) * sc3_pkg::DEF_MAX_WIDTH + c];
    endfunction

    function void note_pixel_request(bit drain, bit [sc3_pkg::PIXEL_W-1:0] pixel);
        int                        w;
        int                        h;
        int                        sum;
        longint                    k;
        bit [sc3_pkg::PIXEL_W-1:0] tap;
        bit [sc3_pkg::PIXEL_W-1:0] centre;
        byte                       coef;
        sc3_pkg::t_result          r;
        w = clamp_dim(width_reg, sc3_pkg::DEF_MAX_WIDTH);
        h = clamp_dim(height_reg, sc3_pkg::DEF_MAX_HEIGHT);
        if (in_row < h) begin
            // drain while pixels are still owed is dropped
            if (drain) return;
            if (in_col < sc3_pkg::DEF_MAX_WIDTH)
                line_pixels[(in_row % sc3_pkg::BANKS) * sc3_pkg::DEF_MAX_WIDTH + in_col] = pixel;
        end
        k = longint'(in_row) * w + in_col;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (k < longint'(out_row) * w + out_col + w + 1) return;
        sum = 0;
        for (int dy = 0; dy < sc3_pkg::TAPS; dy++) begin
            for (int dx = 0; dx < sc3_pkg::TAPS; dx++) begin
                tap  = window_tap(out_row + dy - 1, out_col + dx - 1, w, h);
                coef = kernel_rows[dy][8*dx +: 8];
                sum += int'(tap[7:0]) * int'(coef);
            end
        end
        if (sum < 0) sum = 0;
        if (sum > 255) sum = 255;
        centre = window_tap(out_row, out_col, w, h);
        r.luma = sum[7:0];
        r.cb   = centre[15:8];
        r.cr   = centre[23:16];
        r.last = (out_row >= h - 1) && (out_col >= w - 1);
        expected_pixels.push_back(r);
        if (r.last) begin
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    function void check_output_pixel(bit [sc3_pkg::PIXEL_W-1:0] data, bit tlast);
        sc3_pkg::t_result got;
        sc3_pkg::t_result want;
        got = {tlast, data};
        if (expected_pixels.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected output pixel, expected none, actual %h last %b",
                     $time, data, tlast);
            return;
        end
        want = expected_pixels.pop_front();
        if (got.luma != want.luma) begin
            mismatches++;
            $display("%0t: luma expected %0d actual %0d", $time, want.luma, got.luma);
        end
        if (got.cb != want.cb) begin
            mismatches++;
            $display("%0t: cb expected %0d actual %0d", $time, want.cb, got.cb);
        end
        if (got.cr != want.cr) begin
            mismatches++;
            $display("%0t: cr expected %0d actual %0d", $time, want.cr, got.cr);
        end
        if (got.last != want.last) begin
            mismatches++;
            $display("%0t: tlast expected %b actual %b", $time, want.last, got.last);
        end
    endfunction
endclass

module tb_top;
    import sc3_pkg::*;

    localparam bit     KIND_PIXEL      = 1'b0;
    localparam bit     KIND_DRAIN      = 1'b1;
    localparam int     RANDOM_ITEMS    = 850;
    localparam int     SETTLE_CYCLES   = 12;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     PRESSURE_PHASE  = 2;
    localparam int     WIDE_PHASE      = 5;
    localparam int     TALL_PHASE      = 8;
    localparam longint TIMEOUT         = 20 * 400_000;

    localparam bit [PIXEL_W-1:0] EDGE_PIXELS [6] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'h7F7F7F, 24'hFF00FF, 24'h00FF00
    };

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [PIXEL_W-1:0]    i_s_axis_tdata  = '0;
    logic                  i_s_axis_tuser  = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [PIXEL_W-1:0]    o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    int send_idle_pct  = 31;
    int recv_idle_pct  = 83;
    int hold_off_epoch = 0;
    int regular_items  = 0;

    luma_sharpen_scoreboard sharp_sb = new();

    sharpen_conv3x3_clamp DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT);
        $display("CHECK FAILED");
        $finish;
    end

    // outputs first: a request accepted on this edge cannot complete on it
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                sharp_sb.check_output_pixel(o_m_axis_tdata, o_m_axis_tlast);
            if (i_cfg_valid && o_cfg_ready)
                sharp_sb.set_register(i_cfg_index, i_cfg_data);
            if (i_s_axis_tvalid && o_s_axis_tready)
                sharp_sb.note_pixel_request(i_s_axis_tuser, i_s_axis_tdata);
        end
    end

    // receiver; a new hold-off epoch blocks it for a long stretch
    initial begin
        int seen_epoch;
        int hold_left;
        seen_epoch = 0;
        hold_left  = 0;
        forever begin
            @(negedge i_clk);
            if (seen_epoch != hold_off_epoch) begin
                seen_epoch = hold_off_epoch;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic bit [PIXEL_W-1:0] rand_pixel();
        bit [PIX_W-1:0] ch [3];
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(7))
                0:       ch[i] = '0;
                1:       ch[i] = '1;
                default: ch[i] = PIX_W'($urandom);
            endcase
        end
        return {ch[2], ch[1], ch[0]};
    endfunction

    function automatic bit [KROW_W-1:0] rand_kernel_row();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 24'h7F7F7F;
            3:       return 24'h808080;
            4:       return KROW_MID_RST;
            5:       return KROW_TOP_RST;
            default: return KROW_W'($urandom);
        endcase
    endfunction

    task automatic send_item(bit kind, bit [PIXEL_W-1:0] pixel);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= pixel;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_results_done();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (sharp_sb.expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    // drained requests may still sit in the pipeline without a result
    task automatic settle();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one frame plus its drain, with stray drains and pixel requests in the drain phase
    task automatic run_frame(int w, int h, bit counted, bit allow_pause);
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(24) == 0) send_item(KIND_DRAIN, rand_pixel());
            if (allow_pause && $urandom_range(59) == 0) wait_results_done();
            send_item(KIND_PIXEL, rand_pixel());
        end
        for (int i = 0; i <= w; i++)
            send_item(($urandom_range(3) == 0) ? KIND_PIXEL : KIND_DRAIN, rand_pixel());
        if ($urandom_range(3) == 0) send_item(KIND_DRAIN, rand_pixel());
        if (counted) regular_items += w * h + w + 1;
    endtask

    initial begin
        int             w_eff;
        int             h_eff;
        int             frames;
        int             phase;
        bit [DIM_W-1:0] w_reg;
        bit [DIM_W-1:0] h_reg;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // unmapped indexes, zero sizes taken as 1x1, reset kernel
        for (int j = int'(CFG_HEIGHT) + 1; j < (1 << CFG_IDX_W); j++)
            write_reg(CFG_IDX_W'(j), CFG_DATA_W'($urandom));
        write_reg(CFG_WIDTH, '0);
        write_reg(CFG_HEIGHT, '0);
        send_item(KIND_DRAIN, '0);
        send_item(KIND_PIXEL, '1);
        send_item(KIND_PIXEL, 24'h123456);
        send_item(KIND_DRAIN, '1);
        settle();

        write_reg(CFG_WIDTH, CFG_DATA_W'(3));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(2));
        foreach (EDGE_PIXELS[i])
            send_item(KIND_PIXEL, EDGE_PIXELS[i]);
        send_item(KIND_DRAIN, '0);
        send_item(KIND_PIXEL, '1);
        send_item(KIND_DRAIN, '1);
        send_item(KIND_DRAIN, '0);
        send_item(KIND_DRAIN, '0);

        phase = 0;
        while (regular_items < RANDOM_ITEMS || phase <= TALL_PHASE) begin
            if (regular_items < RANDOM_ITEMS / 3) begin
                send_idle_pct = 31;
                recv_idle_pct = 83;
            end else if (regular_items < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 83;
                recv_idle_pct = 31;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();
            write_reg(CFG_KERNEL_TOP, rand_kernel_row());
            write_reg(CFG_KERNEL_MID, rand_kernel_row());
            write_reg(CFG_KERNEL_BOT, rand_kernel_row());
            if ($urandom_range(4) == 0)
                write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, int'(CFG_HEIGHT) + 1)),
                          CFG_DATA_W'($urandom));
            frames = $urandom_range(3, 1);
            case (phase)
                PRESSURE_PHASE: begin
                    w_reg         = DIM_W'(12);
                    h_reg         = DIM_W'(12);
                    frames        = 1;
                    send_idle_pct = 0;
                end
                WIDE_PHASE: begin
                    w_reg  = DIM_W'(64);
                    h_reg  = DIM_W'(2);
                    frames = 1;
                end
                TALL_PHASE: begin
                    w_reg  = DIM_W'(1);
                    h_reg  = DIM_W'(64);
                    frames = 1;
                end
                default: begin
                    w_reg = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(40, 13))
                                                     : DIM_W'($urandom_range(12, 1));
                    h_reg = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(12, 7))
                                                     : DIM_W'($urandom_range(6, 1));
                end
            endcase
            write_reg(CFG_WIDTH, CFG_DATA_W'(w_reg));
            write_reg(CFG_HEIGHT, CFG_DATA_W'(h_reg));
            w_eff = sharp_sb.clamp_dim(w_reg, DEF_MAX_WIDTH);
            h_eff = sharp_sb.clamp_dim(h_reg, DEF_MAX_HEIGHT);
            // long output stall while requests keep coming
            if (phase == PRESSURE_PHASE) hold_off_epoch++;
            repeat (frames)
                run_frame(w_eff, h_eff, 1'b1, phase != PRESSURE_PHASE);
            phase++;
        end

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sharp_sb.mismatches == 0 && sharp_sb.expected_pixels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/sc3_pkg.sv
rtl/sharpen_conv3x3_clamp.sv
sim/tb_top.sv
